/* src/assert_macros.svh */
// assertion helpers, clocked on clk_i, off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mrc_pkg.sv */
package mrc_pkg;

  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpByte  = 2'd1,
    OpTick  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StTimeout   = 2'd1,
    StCrcErr    = 2'd2,
    StException = 2'd3
  } status_e;

  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [7:0]  ExceptionBit = 8'h80;
  localparam logic [7:0]  LengthMin    = 8'd4;
  localparam logic [15:0] TimeoutReset = 16'd1000;
  localparam logic [15:0] ElapsedMax   = 16'hFFFF;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [7:0] expected_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] function_byte;
    logic [7:0] bytes_received;
  } out_item_t;

endpackage

/* src/mrc_crc_byte.sv */
module mrc_crc_byte import mrc_pkg::*; (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

/* src/modbus_rtu_response_checker.sv */
// Checks Modbus RTU response frames. A start item arms the checker with the
// frame length (clamped to 4 .. FRAME_LENGTH_MAX), byte items feed the frame
// and its CRC-16 (reflected, 0xA001, init 0xFFFF), tick items count
// milliseconds against timeout_limit (register 0, byte address 0). Each frame
// ends with one result item: ok, timeout, CRC mismatch or exception. Items
// are taken one per clock cycle while the result side is not stalled; an item
// waits in the input register, where the one-byte CRC update is done, and its
// result item is then offered from the result register. A result held by a
// stalled receiver holds the input back until it is taken.
module modbus_rtu_response_checker import mrc_pkg::*; #(
  parameter int FRAME_LENGTH_MAX = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  localparam logic [7:0] LenMax = 8'(FRAME_LENGTH_MAX);

  // configuration
  logic [15:0] timeout_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {16'h0000, timeout_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_wr) begin
      timeout_q <= pwdata[15:0];
    end
  end

  // input register
  logic     in_valid_q;
  in_item_t in_item_q;
  logic     advance;

  // result register
  logic      out_valid_q;
  out_item_t out_item_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  // frame state
  logic        armed_q, armed_d;
  logic [7:0]  byte_count_q, byte_count_d;
  logic [7:0]  target_q, target_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] trailer_q, trailer_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [7:0]  second_q, second_d;

  logic [15:0] crc_next;
  logic        res_valid;
  logic [1:0]  res_status;
  logic [7:0]  len;
  logic [8:0]  tgt9;

  mrc_crc_byte u_crc (
    .crc_i  (crc_q),
    .byte_i (in_item_q.rx_byte),
    .crc_o  (crc_next)
  );

  assign tgt9 = {1'b0, target_q};

  always_comb begin
    armed_d      = armed_q;
    byte_count_d = byte_count_q;
    target_d     = target_q;
    crc_d        = crc_q;
    trailer_d    = trailer_q;
    elapsed_d    = elapsed_q;
    second_d     = second_q;
    res_valid    = 1'b0;
    res_status   = StOk;
    len          = in_item_q.expected_length;
    case (in_item_q.opcode)
      OpStart: begin
        if (len < LengthMin) begin
          len = LengthMin;
        end
        if (len > LenMax) begin
          len = LenMax;
        end
        armed_d      = 1'b1;
        byte_count_d = 8'd0;
        target_d     = len;
        crc_d        = CrcInit;
        trailer_d    = 16'h0000;
        elapsed_d    = 16'h0000;
        second_d     = 8'd0;
      end
      OpByte: begin
        if (armed_q) begin
          if (({1'b0, byte_count_q} + 9'd2) < tgt9) begin
            crc_d = crc_next;
          end else if (({1'b0, byte_count_q} + 9'd2) == tgt9) begin
            trailer_d[7:0] = in_item_q.rx_byte;
          end else begin
            trailer_d[15:8] = in_item_q.rx_byte;
          end
          if (byte_count_q == 8'd1) begin
            second_d = in_item_q.rx_byte;
          end
          byte_count_d = byte_count_q + 8'd1;
          if (({1'b0, byte_count_q} + 9'd1) >= tgt9) begin
            armed_d   = 1'b0;
            res_valid = 1'b1;
            if (trailer_d != crc_d) begin
              res_status = StCrcErr;
            end else if ((second_d & ExceptionBit) != 8'd0) begin
              res_status = StException;
            end else begin
              res_status = StOk;
            end
          end
        end
      end
      OpTick: begin
        if (armed_q) begin
          if (elapsed_q != ElapsedMax) begin
            elapsed_d = elapsed_q + 16'd1;
          end
          if (elapsed_d >= timeout_q) begin
            armed_d    = 1'b0;
            res_valid  = 1'b1;
            res_status = StTimeout;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q      <= 1'b0;
      byte_count_q <= 8'd0;
      target_q     <= LengthMin;
      crc_q        <= CrcInit;
      trailer_q    <= 16'h0000;
      elapsed_q    <= 16'h0000;
      second_q     <= 8'd0;
    end else if (advance) begin
      armed_q      <= armed_d;
      byte_count_q <= byte_count_d;
      target_q     <= target_d;
      crc_q        <= crc_d;
      trailer_q    <= trailer_d;
      elapsed_q    <= elapsed_d;
      second_q     <= second_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_item_q.status         <= res_status;
      out_item_q.function_byte  <= second_d;
      out_item_q.bytes_received <= byte_count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // checks
  `ASSERT_NXT(a_idle_after_result, advance && res_valid, !armed_q, "checker still armed after a result")
  `ASSERT_IMP(a_count_below_target, armed_q, byte_count_q < target_q, "byte count reached target while armed")
  `ASSERT_IMP(a_frame_len_min, out_valid_q && (out_item_q.status != StTimeout), out_item_q.bytes_received >= LengthMin, "frame result with short length")

endmodule
